FILE: rtl/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg: shared types and constants for the random sample set
// Capacity, field widths, operation and status codes, modulo request.
// ----------------------------------------------------------------------------
package rss_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int DRAW_W   = 16;
	localparam int STEP_W   = $clog2(DRAW_W);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SAMPLE = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_MISS  = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_EMPTY = 2'd3
	} status_t;

	// request into the modulo unit
	typedef struct packed {
		logic              start;
		logic [DRAW_W-1:0] dividend;
		logic [CNT_W-1:0]  divisor;
	} div_req_t;

endpackage

FILE: rtl/random_sample_set_top.sv
// ----------------------------------------------------------------------------
// random_sample_set_top: set of distinct values with random sampling
// Insert, remove and sample over a dense member store held in one ram.
// ----------------------------------------------------------------------------
// insert/remove: one ram read per member until a hit or the end of the set
//   (a hit ends early); sample: a 16-step modulo, then one ram read; an
//   unused op or an empty sample goes straight to the result
// throughput: one word at a time, the next word is taken the cycle after the
//   result is registered; the result waits while out is stalled
// reset: arst_n clears count and control; ram is never cleared
module random_sample_set_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic signed [31:0] value,
	input  logic [15:0] random_draw,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic signed [31:0] sample
);
	import rss_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SEARCH = 6'b000010,
		ST_MOD    = 6'b000100,
		ST_FETCH  = 6'b001000,
		ST_MOVE   = 6'b010000,
		ST_RESULT = 6'b100000
	} state_t;

	state_t             state_q;
	op_t                op_q;
	logic [DATA_W-1:0]  value_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   rd_q;
	logic               pend_s1;
	logic [ADDR_W-1:0]  idx_s1;
	logic [ADDR_W-1:0]  pos_q;
	status_t            res_stat_q;
	logic [DATA_W-1:0]  res_smp_q;
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [DATA_W-1:0]  sample_q;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [DATA_W-1:0]  ram_wdata;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [DATA_W-1:0]  ram_rdata;

	div_req_t           div_req;
	logic               mod_done;
	logic [CNT_W-1:0]   mod_rem;

	logic               accept;
	logic               hit;
	logic               exhausted;
	logic               issue;
	logic               full;
	logic               out_free;
	logic [CNT_W-1:0]   last_idx;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign hit       = (state_q == ST_SEARCH) && pend_s1 && (ram_rdata == value_q);
	assign exhausted = (state_q == ST_SEARCH) && !pend_s1 && (rd_q == count_q);
	assign issue     = (state_q == ST_SEARCH) && (rd_q < count_q);
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign out_free  = !out_valid_q || out_ready;
	assign last_idx  = count_q - 1'b1;

	// modulo request at accept of a sample word on a non-empty set
	always_comb begin
		div_req.start    = accept && (op_t'(op) == OP_SAMPLE) && (count_q != '0);
		div_req.dividend = random_draw;
		div_req.divisor  = count_q;
	end

	// ram read address select
	always_comb begin
		priority if (hit && (op_q == OP_REMOVE)) begin
			ram_raddr = last_idx[ADDR_W-1:0];
		end else if (state_q == ST_MOD) begin
			ram_raddr = mod_rem[ADDR_W-1:0];
		end else begin
			ram_raddr = rd_q[ADDR_W-1:0];
		end
	end

	// ram write: append on an insert miss with room, move last member on remove
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[ADDR_W-1:0];
		ram_wdata = value_q;
		if (exhausted && (op_q == OP_INSERT) && !full) begin
			ram_we = 1'b1;
		end else if (state_q == ST_MOVE) begin
			ram_we    = 1'b1;
			ram_waddr = pos_q;
			ram_wdata = ram_rdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			rd_q    <= '0;
			pend_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_q    <= '0;
						pend_s1 <= 1'b0;
						unique case (op_t'(op))
							OP_INSERT, OP_REMOVE: state_q <= ST_SEARCH;
							OP_SAMPLE: begin
								state_q <= (count_q == '0) ? ST_RESULT : ST_MOD;
							end
							default: state_q <= ST_RESULT;
						endcase
					end
				end
				ST_SEARCH: begin
					pend_s1 <= issue;
					if (issue) begin
						rd_q <= rd_q + 1'b1;
					end
					if (hit) begin
						state_q <= (op_q == OP_REMOVE) ? ST_MOVE : ST_RESULT;
					end else if (exhausted) begin
						state_q <= ST_RESULT;
						if ((op_q == OP_INSERT) && !full) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_RESULT;
				end
				ST_MOVE: begin
					count_q <= last_idx;
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// word payload and result bookkeeping
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= op_t'(op);
			value_q    <= $unsigned(value);
			res_smp_q  <= '0;
			if ((op_t'(op) == OP_SAMPLE) && (count_q == '0)) begin
				res_stat_q <= STAT_EMPTY;
			end else begin
				res_stat_q <= STAT_DONE;
			end
		end
		if (state_q == ST_SEARCH) begin
			idx_s1 <= rd_q[ADDR_W-1:0];
		end
		if (hit) begin
			pos_q <= idx_s1;
			if (op_q == OP_INSERT) begin
				res_stat_q <= STAT_MISS;
			end
		end else if (exhausted) begin
			if (op_q == OP_REMOVE) begin
				res_stat_q <= STAT_MISS;
			end else if (full) begin
				res_stat_q <= STAT_FULL;
			end
		end
		if (state_q == ST_FETCH) begin
			res_smp_q <= ram_rdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_RESULT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RESULT) && out_free) begin
			status_q <= res_stat_q;
			sample_q <= res_smp_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign sample    = $signed(sample_q);

	// member store
	rss_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// draw modulo count
	rss_mod u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.done  (mod_done),
		.rem   (mod_rem)
	);

`ifndef NO_ASSERTIONS
	// count never passes capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("member count above capacity");

	// a move write shrinks the set by one
	a_move_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOVE) |=> (count_q == $past(last_idx)))
		else $error("remove did not decrement count");

	// modulo finishes only while the sequencer waits on it
	a_mod_state: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == ST_MOD))
		else $error("modulo done outside its state");

	// sampled index stays inside the populated range
	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mod_done && (state_q == ST_MOD)) |-> (mod_rem < count_q))
		else $error("sample index beyond member count");
`endif

endmodule

FILE: rtl/rss_ram.sv
// ----------------------------------------------------------------------------
// rss_ram: generic simple dual-port ram
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/rss_mod.sv
// ----------------------------------------------------------------------------
// rss_mod: iterative modulo unit
// Restoring division, one dividend bit per cycle; remainder valid with done.
// ----------------------------------------------------------------------------
module rss_mod (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rss_pkg::div_req_t       req,
	output logic                    done,
	output logic [rss_pkg::CNT_W-1:0] rem
);
	import rss_pkg::*;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DRAW_W - 1);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [DRAW_W-1:0] num_q;
	logic [CNT_W-1:0]  den_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;
	logic [CNT_W-1:0]  rem_nxt;

	// one restoring step
	always_comb begin
		trial = {rem_q, num_q[DRAW_W-1]};
		diff  = trial - {1'b0, den_q};
		if (trial >= {1'b0, den_q}) begin
			rem_nxt = diff[CNT_W-1:0];
		end else begin
			rem_nxt = trial[CNT_W-1:0];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DRAW_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign done = busy_q && (step_q == STEP_LAST);
	assign rem  = rem_nxt;

endmodule
